[design/ftws_pkg.sv]
// ----------------------------------------------------------------------------
// ftws_pkg
// Shared types and constants for the frame timing window statistics monitor.
// ----------------------------------------------------------------------------
package ftws_pkg;

   localparam int SAMPLE_W = 16;
   localparam int WIN_W    = 15;
   localparam int RUN_W    = 4;
   localparam int TIME_W   = 32;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = 16'sh7fff;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

   localparam logic [WIN_W-1:0] WIN_RESET = 15'd1000;
   localparam logic [RUN_W-1:0] RUN_RESET = 4'd5;

   typedef enum logic [1:0] {
      TREND_NEG    = 2'd0,
      TREND_NONNEG = 2'd1,
      TREND_IDLE   = 2'd2
   } trend_mode_type;

   typedef enum logic {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_TREND_RUN     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [WIN_W-1:0] window_length;
      logic [RUN_W-1:0] run_length;
   } csr_cfg_type;

   typedef struct packed {
      trend_mode_type   mode;
      logic [RUN_W-1:0] runs;
      sample_type       extreme;
   } trend_status_type;

endpackage

[design/ftws_csr.sv]
// ----------------------------------------------------------------------------
// ftws_csr
// APB register bank holding the window length and the trend run length.
// ----------------------------------------------------------------------------
module ftws_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ftws_pkg::CSR_AW-1:0] paddr,
   input  logic [ftws_pkg::CSR_DW-1:0] pwdata,
   output logic [ftws_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output ftws_pkg::csr_cfg_type       cfg
);
   import ftws_pkg::*;

   logic [WIN_W-1:0] window_length_ff, window_length_in;
   logic [RUN_W-1:0] run_length_ff, run_length_in;
   logic             write_hit;
   csr_index_type    index;

   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && pready;
   assign index     = csr_index_type'(paddr[2]);

   always_comb begin
      window_length_in = window_length_ff;
      run_length_in    = run_length_ff;
      if (write_hit) begin
         unique case (index)
            CSR_WINDOW_LENGTH: window_length_in = pwdata[WIN_W-1:0];
            CSR_TREND_RUN:     run_length_in    = pwdata[RUN_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_WINDOW_LENGTH: prdata = CSR_DW'(window_length_ff);
         CSR_TREND_RUN:     prdata = CSR_DW'(run_length_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WIN_RESET;
         run_length_ff    <= RUN_RESET;
      end else begin
         window_length_ff <= window_length_in;
         run_length_ff    <= run_length_in;
      end
   end

   assign cfg.window_length = window_length_ff;
   assign cfg.run_length    = run_length_ff;

endmodule

[design/ftws_trend.sv]
// ----------------------------------------------------------------------------
// ftws_trend
// Trend tracker updated at each window close from the window minimum of a.
// ----------------------------------------------------------------------------
module ftws_trend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          close_en,
   input  ftws_pkg::sample_type          a_min,
   input  logic [ftws_pkg::RUN_W-1:0]    run_length,
   output ftws_pkg::trend_status_type    status_next
);
   import ftws_pkg::*;

   trend_mode_type   mode_ff, mode_in, want;
   logic [RUN_W-1:0] runs_ff, runs_in, runs_base;
   sample_type       extreme_ff, extreme_in, extreme_base;

   always_comb begin
      mode_in      = mode_ff;
      runs_in      = runs_ff;
      extreme_in   = extreme_ff;
      want         = a_min[SAMPLE_W-1] ? TREND_NEG : TREND_NONNEG;
      runs_base    = runs_ff;
      extreme_base = extreme_ff;
      if (want != mode_ff) begin
         // leaving idle counts as a mode change too
         runs_base    = '0;
         extreme_base = (want == TREND_NONNEG) ? SAMPLE_MAX : SAMPLE_MIN;
      end
      if (close_en) begin
         if (a_min == '0) begin
            mode_in = TREND_IDLE;
         end else begin
            if (want == TREND_NEG) begin
               extreme_in = (a_min > extreme_base) ? a_min : extreme_base;
            end else begin
               extreme_in = (a_min < extreme_base) ? a_min : extreme_base;
            end
            runs_in = runs_base + 1'b1;
            mode_in = (runs_in == run_length) ? TREND_IDLE : want;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= TREND_NEG;
         runs_ff    <= '0;
         extreme_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         runs_ff    <= runs_in;
         extreme_ff <= extreme_in;
      end
   end

   assign status_next.mode    = mode_in;
   assign status_next.runs    = runs_in;
   assign status_next.extreme = extreme_in;

endmodule

[design/frame_timing_window_stats_top.sv]
// ----------------------------------------------------------------------------
// frame_timing_window_stats_top
// Windowed frame statistics monitor: wall delta, frame count and min/max
// tracking per window, with a trend tracker on the window minimum of a.
// ----------------------------------------------------------------------------
//   channel   direction   handshake               payload
//   req_*     in          req_valid / req_stall   func, now_ms, a_sample, b_sample
//   rsp_*     out         rsp_valid / rsp_stall   window_closed, trend_*, totals, min/max
//   apb       in/out      psel/penable/pready     window length, trend run length
//
// one transaction per cycle unless req_stall; the result appears in the cycle after
// acceptance, held in the single output register behind the accumulator update logic.
// synchronous reset clears the window, the trend and rsp_valid, not the result data.
// a new transaction is taken while the held result is being drained;
// req_stall rises only when the result register is full and rsp_stall is high.
// ----------------------------------------------------------------------------
module frame_timing_window_stats_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [ftws_pkg::TIME_W-1:0]   req_now_ms,
   input  ftws_pkg::sample_type          req_a_sample,
   input  ftws_pkg::sample_type          req_b_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_window_closed,
   output logic [1:0]                    rsp_trend_state,
   output logic [ftws_pkg::RUN_W-1:0]    rsp_trend_runs,
   output ftws_pkg::sample_type          rsp_trend_extreme,
   output ftws_pkg::sample_type          rsp_frame_total,
   output ftws_pkg::sample_type          rsp_wall_total,
   output ftws_pkg::sample_type          rsp_wall_low,
   output ftws_pkg::sample_type          rsp_wall_high,
   output ftws_pkg::sample_type          rsp_a_low,
   output ftws_pkg::sample_type          rsp_a_high,
   output ftws_pkg::sample_type          rsp_b_low,
   output ftws_pkg::sample_type          rsp_b_high,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ftws_pkg::CSR_AW-1:0]   paddr,
   input  logic [ftws_pkg::CSR_DW-1:0]   pwdata,
   output logic [ftws_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import ftws_pkg::*;

   csr_cfg_type      cfg;
   trend_status_type trend_next;

   logic              accept;
   logic              armed_ff, armed_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in, time_diff;
   sample_type        frame_count_ff, frame_count_in, frame_inc;
   sample_type        wall_sum_ff, wall_sum_in, sum_inc;
   sample_type        wall_min_ff, wall_min_in, wall_max_ff, wall_max_in;
   sample_type        a_min_ff, a_min_in, a_max_ff, a_max_in;
   sample_type        b_min_ff, b_min_in, b_max_ff, b_max_in;
   sample_type        delta;
   logic              close_hit, closed;

   logic              rsp_valid_ff;
   logic              closed_ff;
   trend_status_type  trend_ff;
   sample_type        out_frame_ff, out_sum_ff;
   sample_type        out_wmin_ff, out_wmax_ff, out_amin_ff, out_amax_ff;
   sample_type        out_bmin_ff, out_bmax_ff;

   ftws_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // wrapped wall delta, read as signed at sample width
   assign time_diff = req_now_ms - last_time_ff;
   assign delta     = $signed(time_diff[SAMPLE_W-1:0]);
   assign frame_inc = frame_count_ff + sample_type'(1);
   assign sum_inc   = wall_sum_ff + delta;
   assign close_hit = (sum_inc >= $signed({1'b0, cfg.window_length}))
                      && !frame_inc[SAMPLE_W-1] && (frame_inc != '0);

   always_comb begin
      armed_in       = armed_ff;
      last_time_in   = last_time_ff;
      frame_count_in = frame_count_ff;
      wall_sum_in    = wall_sum_ff;
      wall_min_in    = wall_min_ff;
      wall_max_in    = wall_max_ff;
      a_min_in       = a_min_ff;
      a_max_in       = a_max_ff;
      b_min_in       = b_min_ff;
      b_max_in       = b_max_ff;
      closed         = 1'b0;
      if (accept) begin
         priority if (req_func) begin
            armed_in = 1'b0;
         end else if (!armed_ff) begin
            // arming sample: clear the window and latch the timestamp
            armed_in       = 1'b1;
            last_time_in   = req_now_ms;
            frame_count_in = '0;
            wall_sum_in    = '0;
            wall_min_in    = SAMPLE_MAX;
            wall_max_in    = SAMPLE_MIN;
            a_min_in       = SAMPLE_MAX;
            a_max_in       = SAMPLE_MIN;
            b_min_in       = SAMPLE_MAX;
            b_max_in       = SAMPLE_MIN;
         end else begin
            last_time_in   = req_now_ms;
            frame_count_in = frame_inc;
            wall_sum_in    = sum_inc;
            wall_min_in    = (delta < wall_min_ff) ? delta : wall_min_ff;
            wall_max_in    = (delta > wall_max_ff) ? delta : wall_max_ff;
            a_min_in       = (req_a_sample < a_min_ff) ? req_a_sample : a_min_ff;
            a_max_in       = (req_a_sample > a_max_ff) ? req_a_sample : a_max_ff;
            b_min_in       = (req_b_sample < b_min_ff) ? req_b_sample : b_min_ff;
            b_max_in       = (req_b_sample > b_max_ff) ? req_b_sample : b_max_ff;
            if (close_hit) begin
               closed   = 1'b1;
               armed_in = 1'b0;
            end
         end
      end
   end

   ftws_trend u_trend (
      .clock       (clock),
      .reset       (reset),
      .close_en    (closed),
      .a_min       (a_min_in),
      .run_length  (cfg.run_length),
      .status_next (trend_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         last_time_ff   <= '0;
         frame_count_ff <= '0;
         wall_sum_ff    <= '0;
         wall_min_ff    <= SAMPLE_MAX;
         wall_max_ff    <= SAMPLE_MIN;
         a_min_ff       <= SAMPLE_MAX;
         a_max_ff       <= SAMPLE_MIN;
         b_min_ff       <= SAMPLE_MAX;
         b_max_ff       <= SAMPLE_MIN;
      end else begin
         armed_ff       <= armed_in;
         last_time_ff   <= last_time_in;
         frame_count_ff <= frame_count_in;
         wall_sum_ff    <= wall_sum_in;
         wall_min_ff    <= wall_min_in;
         wall_max_ff    <= wall_max_in;
         a_min_ff       <= a_min_in;
         a_max_ff       <= a_max_in;
         b_min_ff       <= b_min_in;
         b_max_ff       <= b_max_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         closed_ff    <= closed;
         trend_ff     <= trend_next;
         out_frame_ff <= frame_count_in;
         out_sum_ff   <= wall_sum_in;
         out_wmin_ff  <= wall_min_in;
         out_wmax_ff  <= wall_max_in;
         out_amin_ff  <= a_min_in;
         out_amax_ff  <= a_max_in;
         out_bmin_ff  <= b_min_in;
         out_bmax_ff  <= b_max_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_closed = closed_ff;
   assign rsp_trend_state   = trend_ff.mode;
   assign rsp_trend_runs    = trend_ff.runs;
   assign rsp_trend_extreme = trend_ff.extreme;
   assign rsp_frame_total   = out_frame_ff;
   assign rsp_wall_total    = out_sum_ff;
   assign rsp_wall_low      = out_wmin_ff;
   assign rsp_wall_high     = out_wmax_ff;
   assign rsp_a_low         = out_amin_ff;
   assign rsp_a_high        = out_amax_ff;
   assign rsp_b_low         = out_bmin_ff;
   assign rsp_b_high        = out_bmax_ff;

endmodule
